// ===== sv/planar_radius_cross_match_macros.svh =====
// Assertion macros for the checker file of planar_radius_cross_match.
// Depends on nothing; include by bare file name.
`ifndef PLANAR_RADIUS_CROSS_MATCH_MACROS_SVH
`define PLANAR_RADIUS_CROSS_MATCH_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PRCM_ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("prcm assertion failed");

// Concurrent assertion on the block clock aclk and reset aresetn.
`define PRCM_ASSERT(label, prop) `PRCM_ASSERT_CLK(label, aclk, aresetn, prop)

`endif

// ===== sv/prcm_pkg.sv =====
// Shared widths, codes and word types of planar_radius_cross_match.
// Depends on nothing; every module imports it.
package prcm_pkg;

    localparam int COORD_W     = 24;
    localparam int ID_W        = 32;
    localparam int CMD_W       = 2;
    localparam int RAD_W       = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;

    localparam int STORE_DEPTH = 1024;
    localparam int MAX_MATCHES = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int BUF_AW = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
    localparam int N_W    = $clog2(MAX_MATCHES + 1);
    localparam int TOT_W  = $clog2(MAX_MATCHES + 2);
    localparam int QA_W   = $clog2(QUEUE_DEPTH);
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

    localparam int YW         = COORD_W + 2;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int D2_W       = SQ_W + 1;
    localparam int SQRT_ITERS = (D2_W + 1) / 2;
    localparam int DIST_W     = SQRT_ITERS;
    localparam int SI_W       = $clog2(SQRT_ITERS + 1);

    localparam logic [D2_W-1:0] SQRT_BIT0 = D2_W'(1) << (2 * (SQRT_ITERS - 1));

    localparam logic [CMD_W-1:0] CMD_CLEAR  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_LOAD   = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_QUERY  = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_UNUSED = CMD_W'(3);

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSEST = CFG_IDX_W'(1);

    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(256);

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ID_W-1:0]    id;
    } cmd_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ID_W-1:0]    id;
    } store_entry_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [D2_W-1:0] d2;
    } match_word_t;

    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic             closest;
    } cfg_t;

endpackage

// ===== sv/planar_radius_cross_match.sv =====
// Top level of the fixed-radius point join: config registers, front queue, back end.
// Depends on prcm_pkg, prcm_front, prcm_back (and prcm_isqrt below it).
//
//  channel   direction  handshake             payload
//  s_        in         s_valid / s_ready     s_command s_pos_x s_pos_y s_point_id
//  m_        out        m_valid / m_ready     query/ref ids, distance, flags
//  cfg_      in         cfg_valid / cfg_ready cfg_index cfg_data
//
// Steps: clear resets the store count in the back end; a load shifts up each stored
// entry above its slot, then writes the new entry (directly when it lands at slot zero).
// A query skips the entries below the window and measures each entry in the window,
// then emits each buffered match word (or a lone closest or no-match word) through
// the 25-step serial square root.
// Reset is synchronous; no clearing pass, the store is reached only below its count.
// A 4-word queue parts the front from the back; m_ stall holds the back end only
// once its result register is full.

module planar_radius_cross_match (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [prcm_pkg::CMD_W-1:0]            s_command,
    input  logic signed [prcm_pkg::COORD_W-1:0]   s_pos_x,
    input  logic signed [prcm_pkg::COORD_W-1:0]   s_pos_y,
    input  logic [prcm_pkg::ID_W-1:0]             s_point_id,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [prcm_pkg::ID_W-1:0]             m_query_id,
    output logic [prcm_pkg::ID_W-1:0]             m_ref_id_out,
    output logic [prcm_pkg::DIST_W-1:0]           m_distance,
    output logic                                  m_match_valid,
    output logic                                  m_last_result,
    output logic                                  m_truncated,
    output logic                                  m_store_overflow,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [prcm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [prcm_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import prcm_pkg::*;

    logic [RAD_W-1:0] radius_reg;
    logic             closest_reg;
    cfg_t             cfg;
    logic             q_valid;
    cmd_word_t        q_word;
    logic             q_pop;

    // config writes are registered; always ready
    assign cfg_ready = 1'b1;
    assign cfg       = '{radius: radius_reg, closest: closest_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= RADIUS_RESET;
            closest_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RADIUS:  radius_reg  <= cfg_data[RAD_W-1:0];
                CFG_CLOSEST: closest_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // front: accept and classify words, queue them
    prcm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .s_point_id (s_point_id),
        .q_valid    (q_valid),
        .q_word     (q_word),
        .q_pop      (q_pop)
    );

    // back: store upkeep, window scan and result words
    prcm_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .q_valid          (q_valid),
        .q_word           (q_word),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_query_id       (m_query_id),
        .m_ref_id_out     (m_ref_id_out),
        .m_distance       (m_distance),
        .m_match_valid    (m_match_valid),
        .m_last_result    (m_last_result),
        .m_truncated      (m_truncated),
        .m_store_overflow (m_store_overflow)
    );

endmodule

// ===== sv/prcm_front.sv =====
// Front end: accepts command words, drops unused codes, queues the rest.
// Depends on prcm_pkg.
module prcm_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [prcm_pkg::CMD_W-1:0]          s_command,
    input  logic signed [prcm_pkg::COORD_W-1:0] s_pos_x,
    input  logic signed [prcm_pkg::COORD_W-1:0] s_pos_y,
    input  logic [prcm_pkg::ID_W-1:0]           s_point_id,
    output logic                                q_valid,
    output prcm_pkg::cmd_word_t                 q_word,
    input  logic                                q_pop
);
    import prcm_pkg::*;

    cmd_word_t        fifo_reg [QUEUE_DEPTH];
    logic [QA_W-1:0]  wr_ptr_reg;
    logic [QA_W-1:0]  rd_ptr_reg;
    logic [QC_W-1:0]  fill_reg;
    logic             known;
    logic             push;
    logic             pop;

    // classify: only clear, load and query go on to the back end
    assign known   = (s_command == CMD_CLEAR) || (s_command == CMD_LOAD) ||
                     (s_command == CMD_QUERY);
    assign s_ready = (fill_reg != QC_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready && known;
    assign q_valid = (fill_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_word  = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= '{cmd: s_command, x: s_pos_x, y: s_pos_y,
                                      id: s_point_id};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/prcm_isqrt.sv =====
// Bit-serial floor square root, one result bit per cycle.
// Depends on prcm_pkg.
module prcm_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [prcm_pkg::D2_W-1:0]     operand,
    output logic                          done,
    output logic [prcm_pkg::DIST_W-1:0]   root
);
    import prcm_pkg::*;

    logic [D2_W-1:0] rem_reg;
    logic [D2_W-1:0] root_reg;
    logic [D2_W-1:0] bit_reg;
    logic [SI_W-1:0] iter_reg;
    logic            run_reg;
    logic            done_reg;
    logic [D2_W:0]   trial;
    logic            take;

    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign take  = ({1'b0, rem_reg} >= trial);
    assign done  = done_reg;
    assign root  = root_reg[DIST_W-1:0];

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= operand;
            root_reg <= '0;
            bit_reg  <= SQRT_BIT0;
            iter_reg <= '0;
        end else if (run_reg) begin
            if (take) begin
                rem_reg  <= rem_reg - trial[D2_W-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg  <= bit_reg >> 2;
            iter_reg <= iter_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end else if (run_reg && iter_reg == SI_W'(SQRT_ITERS - 1)) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
    end

endmodule

// ===== sv/prcm_back.sv =====
// Back end: sorted point store, window scan, match buffer, result register.
// Depends on prcm_pkg and prcm_isqrt.
module prcm_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  prcm_pkg::cfg_t                    cfg,
    input  logic                              q_valid,
    input  prcm_pkg::cmd_word_t               q_word,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [prcm_pkg::ID_W-1:0]         m_query_id,
    output logic [prcm_pkg::ID_W-1:0]         m_ref_id_out,
    output logic [prcm_pkg::DIST_W-1:0]       m_distance,
    output logic                              m_match_valid,
    output logic                              m_last_result,
    output logic                              m_truncated,
    output logic                              m_store_overflow
);
    import prcm_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_LD_RD   = 4'd1;
    localparam logic [3:0] ST_LD_CHK  = 4'd2;
    localparam logic [3:0] ST_Q_INIT  = 4'd3;
    localparam logic [3:0] ST_SC_RD   = 4'd4;
    localparam logic [3:0] ST_SC_CHK  = 4'd5;
    localparam logic [3:0] ST_SC_SQX  = 4'd6;
    localparam logic [3:0] ST_SC_SQY  = 4'd7;
    localparam logic [3:0] ST_SC_ACC  = 4'd8;
    localparam logic [3:0] ST_SC_END  = 4'd9;
    localparam logic [3:0] ST_EM_RD   = 4'd10;
    localparam logic [3:0] ST_EM_GO   = 4'd11;
    localparam logic [3:0] ST_EM_WAIT = 4'd12;

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        if (d[COORD_W]) begin
            d = -d;
        end
        return d[COORD_W-1:0];
    endfunction

    logic [3:0]          state_reg;
    logic [3:0]          state_next;

    cmd_word_t           cur_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                ovf_reg;
    logic [CNT_W-1:0]    j_reg;
    logic signed [YW-1:0] ylo_reg;
    logic signed [YW-1:0] yhi_reg;
    logic [SQ_W-1:0]     r2_reg;
    logic [COORD_W-1:0]  adx_reg;
    logic [COORD_W-1:0]  ady_reg;
    logic [SQ_W-1:0]     sqx_reg;
    logic [SQ_W-1:0]     sqy_reg;
    logic [SQ_W-1:0]     best_reg;
    logic [ID_W-1:0]     best_id_reg;
    logic                found_reg;
    logic [N_W-1:0]      n_reg;
    logic [TOT_W-1:0]    total_reg;
    logic [N_W-1:0]      k_reg;

    logic                em_from_buf_reg;
    logic [ID_W-1:0]     em_id_reg;
    logic [D2_W-1:0]     em_d2_reg;
    logic                em_match_reg;
    logic                em_last_reg;
    logic                em_trunc_reg;

    logic                m_valid_reg;
    logic [ID_W-1:0]     m_query_id_reg;
    logic [ID_W-1:0]     m_ref_id_reg;
    logic [DIST_W-1:0]   m_distance_reg;
    logic                m_match_reg;
    logic                m_last_reg;
    logic                m_trunc_reg;
    logic                m_ovf_reg;

    store_entry_t        st_mem [STORE_DEPTH];
    store_entry_t        st_rd_reg;
    logic                st_we;
    logic                st_re;
    logic [ADDR_W-1:0]   st_waddr;
    logic [ADDR_W-1:0]   st_raddr;
    store_entry_t        st_wdata;
    store_entry_t        new_entry;

    match_word_t         buf_mem [MAX_MATCHES];
    match_word_t         buf_rd_reg;
    logic                buf_we;
    logic                buf_re;

    logic [COORD_W-1:0]  mul_a;
    logic [COORD_W-1:0]  mul_b;
    logic [SQ_W-1:0]     mul_p;

    logic                ld_move;
    logic signed [YW-1:0] ry_ext;
    logic                below;
    logic                above;
    logic [D2_W-1:0]     d2_sum;
    logic                in_radius;
    logic                closer;
    logic                out_free;

    logic                sq_start;
    logic [D2_W-1:0]     sq_operand;
    logic                sq_done;
    logic [DIST_W-1:0]   sq_root;

    assign new_entry = '{x: cur_reg.x, y: cur_reg.y, id: cur_reg.id};
    assign ld_move   = $signed(st_rd_reg.y) > $signed(cur_reg.y);
    assign ry_ext    = YW'($signed(st_rd_reg.y));
    assign below     = ry_ext < ylo_reg;
    assign above     = ry_ext > yhi_reg;
    assign d2_sum    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign in_radius = d2_sum < {1'b0, r2_reg};
    assign closer    = d2_sum < {1'b0, best_reg};
    assign out_free  = !m_valid_reg || m_ready;
    assign mul_p     = mul_a * mul_b;
    assign sq_operand = em_from_buf_reg ? buf_rd_reg.d2 : em_d2_reg;

    prcm_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .operand (sq_operand),
        .done    (sq_done),
        .root    (sq_root)
    );

    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            st_rd_reg <= st_mem[st_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[n_reg[BUF_AW-1:0]] <= '{id: st_rd_reg.id, d2: d2_sum};
        end
        if (buf_re) begin
            buf_rd_reg <= buf_mem[k_reg[BUF_AW-1:0]];
        end
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        st_we      = 1'b0;
        st_re      = 1'b0;
        st_waddr   = j_reg[ADDR_W-1:0];
        st_raddr   = j_reg[ADDR_W-1:0];
        st_wdata   = new_entry;
        buf_we     = 1'b0;
        buf_re     = 1'b0;
        sq_start   = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_word.cmd == CMD_LOAD && count_reg != CNT_W'(STORE_DEPTH)) begin
                        state_next = ST_LD_RD;
                    end else if (q_word.cmd == CMD_QUERY) begin
                        state_next = ST_Q_INIT;
                    end
                end
            end
            ST_LD_RD: begin
                if (j_reg == '0) begin
                    st_we      = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    st_re      = 1'b1;
                    st_raddr   = ADDR_W'(j_reg - 1'b1);
                    state_next = ST_LD_CHK;
                end
            end
            ST_LD_CHK: begin
                st_we = 1'b1;
                if (ld_move) begin
                    st_wdata   = st_rd_reg;
                    state_next = ST_LD_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_Q_INIT: begin
                mul_a      = cfg.radius;
                mul_b      = cfg.radius;
                state_next = ST_SC_RD;
            end
            ST_SC_RD: begin
                if (j_reg == count_reg) begin
                    state_next = ST_SC_END;
                end else begin
                    st_re      = 1'b1;
                    state_next = ST_SC_CHK;
                end
            end
            ST_SC_CHK: begin
                if (below) begin
                    state_next = ST_SC_RD;
                end else if (above) begin
                    state_next = ST_SC_END;
                end else begin
                    state_next = ST_SC_SQX;
                end
            end
            ST_SC_SQX: begin
                mul_a      = adx_reg;
                mul_b      = adx_reg;
                state_next = ST_SC_SQY;
            end
            ST_SC_SQY: begin
                mul_a      = ady_reg;
                mul_b      = ady_reg;
                state_next = ST_SC_ACC;
            end
            ST_SC_ACC: begin
                buf_we     = !cfg.closest && in_radius && (n_reg < N_W'(MAX_MATCHES));
                state_next = ST_SC_RD;
            end
            ST_SC_END: begin
                state_next = (!cfg.closest && n_reg != '0) ? ST_EM_RD : ST_EM_GO;
            end
            ST_EM_RD: begin
                buf_re     = 1'b1;
                state_next = ST_EM_GO;
            end
            ST_EM_GO: begin
                sq_start   = 1'b1;
                state_next = ST_EM_WAIT;
            end
            ST_EM_WAIT: begin
                if (sq_done && out_free) begin
                    state_next = em_last_reg ? ST_IDLE : ST_EM_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_EM_WAIT && sq_done && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE && q_valid) begin
                if (q_word.cmd == CMD_CLEAR) begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end else if (q_word.cmd == CMD_LOAD && count_reg == CNT_W'(STORE_DEPTH)) begin
                    ovf_reg <= 1'b1;
                end
            end
            if ((state_reg == ST_LD_RD && j_reg == '0) ||
                (state_reg == ST_LD_CHK && !ld_move)) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cur_reg <= q_word;
                    j_reg   <= count_reg;
                end
            end
            ST_LD_CHK: begin
                if (ld_move) begin
                    j_reg <= j_reg - 1'b1;
                end
            end
            ST_Q_INIT: begin
                r2_reg      <= mul_p;
                best_reg    <= mul_p;
                ylo_reg     <= YW'($signed(cur_reg.y)) - $signed({2'b00, cfg.radius});
                yhi_reg     <= YW'($signed(cur_reg.y)) + $signed({2'b00, cfg.radius});
                best_id_reg <= '0;
                found_reg   <= 1'b0;
                n_reg       <= '0;
                total_reg   <= '0;
                j_reg       <= '0;
            end
            ST_SC_CHK: begin
                if (below) begin
                    j_reg <= j_reg + 1'b1;
                end
                adx_reg <= abs_diff(cur_reg.x, st_rd_reg.x);
                ady_reg <= abs_diff(cur_reg.y, st_rd_reg.y);
            end
            ST_SC_SQX: begin
                sqx_reg <= mul_p;
            end
            ST_SC_SQY: begin
                sqy_reg <= mul_p;
            end
            ST_SC_ACC: begin
                j_reg <= j_reg + 1'b1;
                if (cfg.closest) begin
                    if (closer) begin
                        best_reg    <= d2_sum[SQ_W-1:0];
                        best_id_reg <= st_rd_reg.id;
                        found_reg   <= 1'b1;
                    end
                end else if (in_radius) begin
                    if (total_reg != TOT_W'(MAX_MATCHES + 1)) begin
                        total_reg <= total_reg + 1'b1;
                    end
                    if (n_reg < N_W'(MAX_MATCHES)) begin
                        n_reg <= n_reg + 1'b1;
                    end
                end
            end
            ST_SC_END: begin
                k_reg        <= '0;
                em_last_reg  <= 1'b1;
                em_trunc_reg <= !cfg.closest && (total_reg > TOT_W'(MAX_MATCHES));
                if (!cfg.closest && n_reg != '0) begin
                    em_from_buf_reg <= 1'b1;
                end else begin
                    // closest pick, or the single no-match word
                    em_from_buf_reg <= 1'b0;
                    em_match_reg    <= cfg.closest && found_reg;
                    em_id_reg       <= cfg.closest ? best_id_reg : '0;
                    em_d2_reg       <= (cfg.closest && found_reg) ? {1'b0, best_reg} : '0;
                end
            end
            ST_EM_GO: begin
                if (em_from_buf_reg) begin
                    em_id_reg    <= buf_rd_reg.id;
                    em_match_reg <= 1'b1;
                    em_last_reg  <= (N_W'(k_reg + 1'b1) == n_reg);
                end
            end
            ST_EM_WAIT: begin
                if (sq_done && out_free) begin
                    k_reg          <= k_reg + 1'b1;
                    m_query_id_reg <= cur_reg.id;
                    m_ref_id_reg   <= em_id_reg;
                    m_distance_reg <= sq_root;
                    m_match_reg    <= em_match_reg;
                    m_last_reg     <= em_last_reg;
                    m_trunc_reg    <= em_trunc_reg;
                    m_ovf_reg      <= ovf_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_query_id       = m_query_id_reg;
    assign m_ref_id_out     = m_ref_id_reg;
    assign m_distance       = m_distance_reg;
    assign m_match_valid    = m_match_reg;
    assign m_last_result    = m_last_reg;
    assign m_truncated      = m_trunc_reg;
    assign m_store_overflow = m_ovf_reg;

endmodule

// ===== sv/prcm_checker.sv =====
// Port-level checks on planar_radius_cross_match result words, bound to the top.
// Depends on prcm_pkg and planar_radius_cross_match_macros.svh.
`include "planar_radius_cross_match_macros.svh"

module prcm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [prcm_pkg::ID_W-1:0]     m_query_id,
    input logic [prcm_pkg::ID_W-1:0]     m_ref_id_out,
    input logic [prcm_pkg::DIST_W-1:0]   m_distance,
    input logic                          m_match_valid,
    input logic                          m_last_result,
    input logic                          m_truncated
);
    import prcm_pkg::*;

    // hold a stalled word
    `PRCM_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_query_id) && $stable(m_distance) && $stable(m_last_result))

    // a no-match word is alone, empty and untruncated
    `PRCM_ASSERT(a_nomatch_shape, m_valid && !m_match_valid |-> m_last_result && m_ref_id_out == '0 && m_distance == '0 && !m_truncated)

    // truncation marks only real matches
    `PRCM_ASSERT(a_trunc_match, m_valid && m_truncated |-> m_match_valid)

endmodule

bind planar_radius_cross_match prcm_checker u_checker (.*);
